// ===== hw/rtl/rnc_pkg.sv =====
package rnc_pkg;

  localparam int BASE_W = 6;
  localparam int CHAR_W = 8;
  localparam int FRAC_W = 64;
  localparam int FCNT_W = 4;
  localparam int QBIT_W = 6;

  localparam logic [BASE_W-1:0] BASE_MIN        = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX        = 6'd36;
  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 6'd10;
  localparam logic [BASE_W-1:0] DEST_BASE_RST   = 6'd2;

  localparam logic CFG_SOURCE_BASE = 1'b0;
  localparam logic CFG_DEST_BASE   = 1'b1;

  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_out;
    logic              error_out;
  } out_item_t;

  typedef enum logic [1:0] {
    K_DIGIT,
    K_DOT,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BASE_W-1:0] digit;
    logic              last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_IDIV,
    ST_IPUSH,
    ST_IRD,
    ST_IOUT,
    ST_DOT,
    ST_FMUL,
    ST_FDIV,
    ST_FOUT,
    ST_ERR
  } state_t;

  function automatic logic base_ok(input logic [BASE_W-1:0] b);
    base_ok = (b >= BASE_MIN) && (b <= BASE_MAX);
  endfunction

endpackage

// ===== hw/rtl/rnc_front.sv =====
module rnc_front import rnc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BASE_W-1:0] source_base,
  input  logic              in_push,
  input  in_item_t          in_data,
  output logic              in_full,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output cmd_t              cmd
);

  logic [6:0] dval;
  cmd_t       cls;
  logic       push;
  logic       pop;
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  cmd_t       q_r [2];

  // digit value, 64 when the character is no digit at all
  always_comb begin
    dval = 7'd64;
    if (in_data.char_in >= CH_0 && in_data.char_in <= CH_9) begin
      dval = 7'(in_data.char_in - CH_0);
    end else if (in_data.char_in >= CH_LA && in_data.char_in <= CH_LZ) begin
      dval = 7'(in_data.char_in - CH_LA + 8'd10);
    end else if (in_data.char_in >= CH_UA && in_data.char_in <= CH_UZ) begin
      dval = 7'(in_data.char_in - CH_UA + 8'd10);
    end
  end

  always_comb begin
    cls.digit = dval[BASE_W-1:0];
    cls.last  = in_data.last_in;
    if (!base_ok(source_base)) begin
      cls.kind = K_BAD;
    end else if (in_data.char_in == CH_DOT) begin
      cls.kind = K_DOT;
    end else if (dval >= {1'b0, source_base}) begin
      cls.kind = K_BAD;
    end else begin
      cls.kind = K_DIGIT;
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule

// ===== hw/rtl/rnc_back.sv =====
module rnc_back import rnc_pkg::*; #(
  parameter int INT_BITS               = 32,
  parameter int MAX_IN_FRACTION_DIGITS = 12,
  parameter int OUT_FRACTION_DIGITS    = 12,
  parameter int STACK_DEPTH            = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BASE_W-1:0] source_base,
  input  logic [BASE_W-1:0] dest_base,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_data
);

  localparam int STEP_W = $clog2(INT_BITS + 1);
  localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int OC_W   = $clog2(OUT_FRACTION_DIGITS + 1);
  localparam int PROD_W = FRAC_W + BASE_W;
  localparam int WIDE_W = INT_BITS + BASE_W + 1;

  state_t                state_r, state_nxt;
  logic [INT_BITS-1:0]   acc_r, acc_nxt;
  logic [FRAC_W-1:0]     num_r, num_nxt;
  logic [FRAC_W-1:0]     den_r, den_nxt;
  logic [FCNT_W-1:0]     fcnt_r, fcnt_nxt;
  logic                  infrac_r, infrac_nxt;
  logic                  err_r, err_nxt;
  logic [INT_BITS-1:0]   dvd_r, dvd_nxt;
  logic [BASE_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DEP_W-1:0]      depth_r, depth_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [QBIT_W-1:0]     q_r, q_nxt;
  logic [OC_W-1:0]       ocnt_r, ocnt_nxt;
  logic [BASE_W-1:0]     rd_data_r;
  logic [BASE_W-1:0]     stack [STACK_DEPTH];

  logic [WIDE_W-1:0]     wide;
  logic [BASE_W:0]       trial;
  logic [PROD_W-1:0]     den_sh;
  logic [DEP_W-1:0]      depth_m1;
  logic                  stk_we;
  logic                  stk_re;
  logic                  push_o;
  out_item_t             item_o;
  logic                  lst;

  logic                  ofull;
  logic [1:0]            ocnt_f_r;
  logic                  owp_r;
  logic                  orp_r;
  out_item_t             ofifo_r [2];

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [BASE_W-1:0] d);
    if (d < 6'd10) to_ascii = CH_0 + CHAR_W'(d);
    else to_ascii = CH_UA + CHAR_W'(d) - 8'd10;
  endfunction

  assign wide = WIDE_W'(acc_r) * WIDE_W'(source_base) + WIDE_W'(cmd.digit);
  assign trial = {rem_r, dvd_r[INT_BITS-1]};
  assign den_sh = PROD_W'(den_r) << step_r[2:0];
  assign depth_m1 = depth_r - 1'b1;

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    fcnt_nxt   = fcnt_r;
    infrac_nxt = infrac_r;
    err_nxt    = err_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    depth_nxt  = depth_r;
    prod_nxt   = prod_r;
    q_nxt      = q_r;
    ocnt_nxt   = ocnt_r;
    cmd_pop    = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    push_o     = 1'b0;
    item_o     = '{char_out: CH_NONE, last_out: 1'b0, error_out: 1'b0};
    lst        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_BAD: err_nxt = 1'b1;
            K_DOT: begin
              if (infrac_r) err_nxt = 1'b1;
              infrac_nxt = 1'b1;
            end
            K_DIGIT: begin
              if (!err_r) begin
                if (!infrac_r) begin
                  if (|wide[WIDE_W-1:INT_BITS]) err_nxt = 1'b1;
                  else acc_nxt = wide[INT_BITS-1:0];
                end else if (fcnt_r >= FCNT_W'(MAX_IN_FRACTION_DIGITS)) begin
                  err_nxt = 1'b1;
                end else begin
                  num_nxt  = num_r * FRAC_W'(source_base) + FRAC_W'(cmd.digit);
                  den_nxt  = den_r * FRAC_W'(source_base);
                  fcnt_nxt = fcnt_r + 1'b1;
                end
              end
            end
            default: err_nxt = 1'b1;
          endcase
          if (cmd.last) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (err_r || !base_ok(dest_base)) begin
          state_nxt = ST_ERR;
        end else begin
          dvd_nxt   = acc_r;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(INT_BITS - 1);
          state_nxt = ST_IDIV;
        end
      end
      ST_IDIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, dest_base}) begin
          rem_nxt = BASE_W'(trial - {1'b0, dest_base});
          dvd_nxt = {dvd_r[INT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial[BASE_W-1:0];
          dvd_nxt = {dvd_r[INT_BITS-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_IPUSH;
      end
      ST_IPUSH: begin
        if (depth_r == DEP_W'(STACK_DEPTH)) begin
          state_nxt = ST_ERR;
        end else begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
          if (dvd_r == '0) begin
            state_nxt = ST_IRD;
          end else begin
            rem_nxt   = '0;
            step_nxt  = STEP_W'(INT_BITS - 1);
            state_nxt = ST_IDIV;
          end
        end
      end
      ST_IRD: begin
        stk_re    = 1'b1;
        depth_nxt = depth_m1;
        state_nxt = ST_IOUT;
      end
      ST_IOUT: begin
        if (!ofull) begin
          push_o = 1'b1;
          lst    = (depth_r == '0) && (fcnt_r == '0);
          item_o = '{char_out: to_ascii(rd_data_r), last_out: lst, error_out: 1'b0};
          if (depth_r != '0) state_nxt = ST_IRD;
          else if (fcnt_r != '0) state_nxt = ST_DOT;
          else state_nxt = ST_IDLE;
        end
      end
      ST_DOT: begin
        if (!ofull) begin
          push_o   = 1'b1;
          lst      = (num_r == '0);
          item_o   = '{char_out: CH_DOT, last_out: lst, error_out: 1'b0};
          ocnt_nxt = '0;
          state_nxt = lst ? ST_IDLE : ST_FMUL;
        end
      end
      ST_FMUL: begin
        prod_nxt  = PROD_W'(num_r) * PROD_W'(dest_base);
        q_nxt     = '0;
        step_nxt  = STEP_W'(QBIT_W - 1);
        state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        // quotient stays below the base, so six restoring steps suffice
        if (prod_r >= den_sh) begin
          prod_nxt = prod_r - den_sh;
          q_nxt[step_r[2:0]] = 1'b1;
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        if (!ofull) begin
          push_o   = 1'b1;
          lst      = (ocnt_r == OC_W'(OUT_FRACTION_DIGITS - 1)) || (prod_r == '0);
          item_o   = '{char_out: to_ascii(q_r), last_out: lst, error_out: 1'b0};
          num_nxt  = prod_r[FRAC_W-1:0];
          ocnt_nxt = ocnt_r + 1'b1;
          state_nxt = lst ? ST_IDLE : ST_FMUL;
        end
      end
      ST_ERR: begin
        if (!ofull) begin
          push_o    = 1'b1;
          item_o    = '{char_out: CH_NONE, last_out: 1'b1, error_out: 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // number done: back to a clean slate
    if (push_o && item_o.last_out) begin
      acc_nxt    = '0;
      num_nxt    = '0;
      den_nxt    = FRAC_W'(1);
      fcnt_nxt   = '0;
      infrac_nxt = 1'b0;
      err_nxt    = 1'b0;
      depth_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_r    <= '0;
      num_r    <= '0;
      den_r    <= FRAC_W'(1);
      fcnt_r   <= '0;
      infrac_r <= 1'b0;
      err_r    <= 1'b0;
      depth_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      fcnt_r   <= fcnt_nxt;
      infrac_r <= infrac_nxt;
      err_r    <= err_nxt;
      depth_r  <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
    ocnt_r <= ocnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack[depth_r[AW-1:0]] <= rem_r;
    if (stk_re) rd_data_r <= stack[depth_m1[AW-1:0]];
  end

  // result queue
  assign ofull     = (ocnt_f_r == 2'd2);
  assign out_empty = (ocnt_f_r == 2'd0);
  assign out_data  = ofifo_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_f_r <= 2'd0;
      owp_r    <= 1'b0;
      orp_r    <= 1'b0;
    end else begin
      ocnt_f_r <= ocnt_f_r + {1'b0, push_o} - {1'b0, out_pop && !out_empty};
      if (push_o) owp_r <= ~owp_r;
      if (out_pop && !out_empty) orp_r <= ~orp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_o) ofifo_r[owp_r] <= item_o;
  end

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEP_W'(STACK_DEPTH))
    else $error("digit stack overrun");
  a_frac_proper: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FMUL) |-> (num_r != '0 && num_r < den_r))
    else $error("fraction remainder not proper");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o && item_o.last_out) |=> (state_r == ST_IDLE && !err_r && depth_r == '0))
    else $error("state not cleared after last item");
  a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE && cmd_valid))
    else $error("command taken while busy");
`endif

endmodule

// ===== hw/rtl/radix_number_converter.sv =====
// A character that is not last passes the command queue and is then taken by the engine.
// Last character: a check step, then the bit-serial divider pushes each integer digit onto the
// stack RAM, the digits are read back out of it, then each fraction digit is multiplied and divided.
// Throughput: one character per cycle while the number builds; the conversion loop sets the rest.
// Reset (rst_n low, synchronous): queues empty, number state cleared, bases back to 10 and 2.
module radix_number_converter import rnc_pkg::*; #(
  parameter int INT_BITS               = 32,
  parameter int MAX_IN_FRACTION_DIGITS = 12,
  parameter int OUT_FRACTION_DIGITS    = 12,
  parameter int STACK_DEPTH            = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_data
);

  logic [BASE_W-1:0] src_base_r;
  logic [BASE_W-1:0] dst_base_r;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r <= SOURCE_BASE_RST;
      dst_base_r <= DEST_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_BASE: src_base_r <= cfg_data;
        CFG_DEST_BASE:   dst_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rnc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .source_base (src_base_r),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd)
  );

  rnc_back #(
    .INT_BITS               (INT_BITS),
    .MAX_IN_FRACTION_DIGITS (MAX_IN_FRACTION_DIGITS),
    .OUT_FRACTION_DIGITS    (OUT_FRACTION_DIGITS),
    .STACK_DEPTH            (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .source_base (src_base_r),
    .dest_base   (dst_base_r),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule
